FILE: sv/assert_macros.svh
// Assertion helpers for the card poll sequencer.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define RCPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("rcps assertion failed: same-cycle check");

`define RCPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("rcps assertion failed: next-cycle check");

`else

`define RCPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define RCPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: sv/rcps_pkg.sv
`timescale 1ns / 1ps

package rcps_pkg;

	// Input action codes.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_RX    = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	// Result kind codes.
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_PRESENT = 2'd1;
	localparam logic [1:0] KIND_ID      = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_GAP     = 1'b1;

	localparam logic [23:0] TIMEOUT_RESET = 24'd1000;
	localparam logic [23:0] GAP_RESET     = 24'd100;

	// Response lengths in bytes.
	localparam logic [3:0] REQ_REPLY_LEN = 4'd8;
	localparam logic [3:0] AC_REPLY_LEN  = 4'd10;

	// Positions inside a response.
	localparam logic [3:0] STATUS_POS   = 4'd2;
	localparam logic [3:0] ID_FIRST_POS = 4'd4;
	localparam logic [3:0] ID_LAST_POS  = 4'd7;

	typedef enum logic {
		FR_REQ,
		FR_AC
	} frame_t;

	// Index of the final byte of each transmit frame.
	function automatic logic [2:0] frame_last_idx(frame_t f);
		logic [2:0] r;
		unique case (f)
			FR_REQ: r = 3'd6;
			FR_AC:  r = 3'd7;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	// Transmit frame contents; the checksum is the inverted XOR of the earlier bytes.
	function automatic logic [7:0] frame_byte(frame_t f, logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (f == FR_REQ) begin
			unique case (i)
				3'd0: r = 8'h07;
				3'd1: r = 8'h02;
				3'd2: r = 8'h41;
				3'd3: r = 8'h01;
				3'd4: r = 8'h52;
				3'd5: r = 8'hE8;
				3'd6: r = 8'h03;
				default: r = 8'h00;
			endcase
		end else begin
			unique case (i)
				3'd0: r = 8'h08;
				3'd1: r = 8'h02;
				3'd2: r = 8'h42;
				3'd3: r = 8'h02;
				3'd4: r = 8'h93;
				3'd5: r = 8'h00;
				3'd6: r = 8'h26;
				3'd7: r = 8'h03;
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

endpackage

FILE: sv/rfid_card_poll_sequencer_top.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     in_valid / in_stall       action, rx_byte
// output    out_valid / out_stall     kind, tx_byte, card_id, last
// config    cfg_we                    cfg_index, cfg_data
//
// Each input beat updates the poll state at the edge that takes it, and its results load
// the output register. One input beat per cycle is sustained while
// each beat causes at most one result and the output is not stalled. A beat that sends
// a frame holds the output for 7 or 8 beats; new input is stalled until its final beat
// leaves, so the output register sets the rate.
// Reset (arst_n low) returns to idle with the default timeout and gap, and no clearing pass.
`include "assert_macros.svh"

module rfid_card_poll_sequencer_top import rcps_pkg::*; #(
	parameter int TIMER_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic [31:0] card_id,
	output logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_REQ_WAIT,
		PH_REQ_GAP,
		PH_AC_WAIT,
		PH_AC_GAP
	} phase_t;

	localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF >> (32 - TIMER_BITS);

	phase_t                  phase_q, phase_d;
	logic [TIMER_BITS-1:0]   tick_q, tick_d, tick_inc;
	logic [3:0]              rx_count_q, rx_count_d, rx_inc, need;
	logic [7:0]              status_q, status_d;
	logic [31:0]             id_q, id_d;
	logic [23:0]             timeout_q, gap_q;
	logic [31:0]             tick_ext, lim_to, lim_gap;

	logic                    out_valid_q;
	logic [1:0]              out_kind_q;
	frame_t                  out_frame_q;
	logic [2:0]              out_idx_q;
	logic [31:0]             out_id_q;

	logic                    emit_v;
	logic [1:0]              emit_kind;
	frame_t                  emit_frame;
	logic [31:0]             emit_id;

	logic                    in_fire, out_fire, beat_last;

	// Output beat presentation from the result register.
	assign beat_last = (out_kind_q != KIND_TX) || (out_idx_q == frame_last_idx(out_frame_q));
	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign tx_byte   = (out_kind_q == KIND_TX) ? frame_byte(out_frame_q, out_idx_q) : 8'h00;
	assign card_id   = out_id_q;
	assign last      = beat_last;

	// Handshakes: input waits only while a result is pending past this cycle.
	assign out_fire = out_valid_q && !out_stall;
	assign in_stall = out_valid_q && !(out_fire && beat_last);
	assign in_fire  = in_valid && !in_stall;

	// Saturating timer and clamped limits.
	assign tick_inc = (&tick_q) ? tick_q : tick_q + TIMER_BITS'(1);
	assign tick_ext = 32'(tick_inc);
	assign lim_to   = (32'(timeout_q) > TIMER_MAX) ? TIMER_MAX : 32'(timeout_q);
	assign lim_gap  = (32'(gap_q) > TIMER_MAX) ? TIMER_MAX : 32'(gap_q);
	assign rx_inc   = rx_count_q + 4'd1;
	assign need     = (phase_q == PH_REQ_WAIT) ? REQ_REPLY_LEN : AC_REPLY_LEN;

	// Next poll state and the results caused by the current input beat.
	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		rx_count_d = rx_count_q;
		status_d   = status_q;
		id_d       = id_q;
		emit_v     = 1'b0;
		emit_kind  = KIND_TX;
		emit_frame = FR_REQ;
		emit_id    = 32'h0;
		unique case (action)
			ACT_START: begin
				emit_v     = 1'b1;
				emit_frame = FR_REQ;
				phase_d    = PH_REQ_WAIT;
				tick_d     = '0;
				rx_count_d = 4'd0;
				status_d   = 8'h00;
				id_d       = 32'h0;
			end
			ACT_TICK: begin
				if (phase_q == PH_REQ_WAIT || phase_q == PH_AC_WAIT) begin
					tick_d = tick_inc;
					if (tick_ext >= lim_to) begin
						phase_d = (phase_q == PH_REQ_WAIT) ? PH_REQ_GAP : PH_AC_GAP;
						tick_d  = '0;
					end
				end else if (phase_q == PH_REQ_GAP || phase_q == PH_AC_GAP) begin
					tick_d = tick_inc;
					if (tick_ext >= lim_gap) begin
						emit_v     = 1'b1;
						emit_frame = (phase_q == PH_REQ_GAP) ? FR_AC : FR_REQ;
						phase_d    = (phase_q == PH_REQ_GAP) ? PH_AC_WAIT : PH_REQ_WAIT;
						tick_d     = '0;
						rx_count_d = 4'd0;
						status_d   = 8'h00;
						id_d       = 32'h0;
					end
				end
			end
			ACT_RX: begin
				if (phase_q == PH_REQ_WAIT || phase_q == PH_AC_WAIT) begin
					if (rx_count_q == STATUS_POS) begin
						status_d = rx_byte;
					end
					if (rx_count_q >= ID_FIRST_POS && rx_count_q <= ID_LAST_POS) begin
						id_d = {rx_byte, id_q[31:8]};
					end
					rx_count_d = rx_inc;
					if (rx_inc >= need) begin
						rx_count_d = 4'd0;
						tick_d     = '0;
						if (phase_q == PH_REQ_WAIT) begin
							emit_v    = (status_q == 8'h00);
							emit_kind = KIND_PRESENT;
							phase_d   = PH_REQ_GAP;
						end else if (status_q == 8'h00) begin
							emit_v    = 1'b1;
							emit_kind = KIND_ID;
							emit_id   = id_q;
							phase_d   = PH_IDLE;
						end else begin
							phase_d = PH_AC_GAP;
						end
					end
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Poll state, configuration registers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			rx_count_q  <= 4'd0;
			status_q    <= 8'h00;
			id_q        <= 32'h0;
			timeout_q   <= TIMEOUT_RESET;
			gap_q       <= GAP_RESET;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_TX;
			out_frame_q <= FR_REQ;
			out_idx_q   <= 3'd0;
			out_id_q    <= 32'h0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TIMEOUT) begin
					timeout_q <= cfg_data;
				end else begin
					gap_q <= cfg_data;
				end
			end
			if (in_fire) begin
				phase_q    <= phase_d;
				tick_q     <= tick_d;
				rx_count_q <= rx_count_d;
				status_q   <= status_d;
				id_q       <= id_d;
			end
			if (in_fire && emit_v) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= emit_kind;
				out_frame_q <= emit_frame;
				out_idx_q   <= 3'd0;
				out_id_q    <= emit_id;
			end else if (out_fire) begin
				if (beat_last) begin
					out_valid_q <= 1'b0;
				end else begin
					out_idx_q <= out_idx_q + 3'd1;
				end
			end
		end
	end

	// A beat that causes results always leaves the result register loaded.
	`RCPS_ASSERT_NXT(a_emit_loads, clk, arst_n, in_fire && emit_v, out_valid_q && out_idx_q == 3'd0)
	// A frame beat that is not the last advances to the next byte.
	`RCPS_ASSERT_NXT(a_frame_steps, clk, arst_n, out_fire && !beat_last, out_valid_q && out_idx_q == $past(out_idx_q) + 3'd1)
	// While waiting for a reply the byte count stays inside the reply length.
	`RCPS_ASSERT_IMP(a_rx_bound, clk, arst_n, phase_q == PH_REQ_WAIT, rx_count_q < REQ_REPLY_LEN)
	`RCPS_ASSERT_IMP(a_rx_bound_ac, clk, arst_n, phase_q == PH_AC_WAIT, rx_count_q < AC_REPLY_LEN)
	// Idle follows only reset or a finished exchange, so no reply is half counted.
	`RCPS_ASSERT_IMP(a_idle_clean, clk, arst_n, phase_q == PH_IDLE, rx_count_q == 4'd0)

endmodule
